// ----- hw/rtl/abcd_pkg.sv -----
package abcd_pkg;

   localparam int DEF_TABLE_ENTRIES = 128;

   localparam int FRAME_TYPE_W = 16;
   localparam int IP_W         = 32;
   localparam int MAC_W        = 48;

   localparam logic [FRAME_TYPE_W-1:0] ARP_ETHERTYPE = 16'h0806;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - MAC_W - 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

// ----- hw/rtl/abcd_table.sv -----
module abcd_table
   import abcd_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [IP_W-1:0]  rd_ip,
   output logic [MAC_W-1:0] rd_mac,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [IP_W-1:0]  wr_ip,
   input  logic [MAC_W-1:0] wr_mac
);

   logic [IP_W-1:0]  ip_mem [TABLE_ENTRIES];
   logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];
   logic [IP_W-1:0]  rd_ip_ff;
   logic [MAC_W-1:0] rd_mac_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ip_mem[wr_addr]  <= wr_ip;
         mac_mem[wr_addr] <= wr_mac;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ip_ff  <= ip_mem[rd_addr];
         rd_mac_ff <= mac_mem[rd_addr];
      end
   end

   assign rd_ip  = rd_ip_ff;
   assign rd_mac = rd_mac_ff;

endmodule

// ----- hw/rtl/abcd_ctrl.sv -----
module abcd_ctrl
   import abcd_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [FRAME_TYPE_W-1:0] req_frame_type,
   input  logic [IP_W-1:0]         req_ip,
   input  logic [MAC_W-1:0]        req_mac,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_arp,
   output logic                    rsp_conflict,
   output logic                    rsp_learned,
   output logic                    rsp_table_full,
   output logic [MAC_W-1:0]        rsp_bound_mac,
   output logic                    rd_en,
   output logic [IDX_W-1:0]        rd_addr,
   input  logic [IP_W-1:0]         rd_ip,
   input  logic [MAC_W-1:0]        rd_mac,
   output logic                    wr_en,
   output logic [IDX_W-1:0]        wr_addr,
   output logic [IP_W-1:0]         wr_ip,
   output logic [MAC_W-1:0]        wr_mac
);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [IP_W-1:0]  ip_ff, ip_in;
   logic [MAC_W-1:0] mac_ff, mac_in;
   logic             is_arp_ff, is_arp_in;
   logic             conflict_ff, conflict_in;
   logic             learned_ff, learned_in;
   logic             full_ff, full_in;
   logic [MAC_W-1:0] bound_ff, bound_in;
   logic             hit;

   // shared compare unit: one stored entry per cycle
   assign hit = pend_ff && (rd_ip == ip_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ip_ff       <= ip_in;
      mac_ff      <= mac_in;
      is_arp_ff   <= is_arp_in;
      conflict_ff <= conflict_in;
      learned_ff  <= learned_in;
      full_ff     <= full_in;
      bound_ff    <= bound_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      ip_in       = ip_ff;
      mac_in      = mac_ff;
      is_arp_in   = is_arp_ff;
      conflict_in = conflict_ff;
      learned_in  = learned_ff;
      full_in     = full_ff;
      bound_in    = bound_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ip_in       = req_ip;
               mac_in      = req_mac;
               issue_in    = '0;
               pend_in     = 1'b0;
               conflict_in = 1'b0;
               learned_in  = 1'b0;
               full_in     = 1'b0;
               bound_in    = '0;
               is_arp_in   = (req_frame_type == ARP_ETHERTYPE);
               state_in    = (req_frame_type == ARP_ETHERTYPE) ? ST_SCAN : ST_RESP;
            end
         end
         ST_SCAN: begin
            priority if (hit) begin
               conflict_in = (rd_mac != mac_ff);
               bound_in    = (rd_mac != mac_ff) ? rd_mac : '0;
               pend_in     = 1'b0;
               state_in    = ST_RESP;
            end else if (issue_ff < count_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_RESP;
               if (count_ff < FULL_COUNT) begin
                  wr_en      = 1'b1;
                  learned_in = 1'b1;
                  count_in   = count_ff + 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr        = issue_ff[IDX_W-1:0];
   assign wr_addr        = count_ff[IDX_W-1:0];
   assign wr_ip          = ip_ff;
   assign wr_mac         = mac_ff;
   assign rsp_is_arp     = is_arp_ff;
   assign rsp_conflict   = conflict_ff;
   assign rsp_learned    = learned_ff;
   assign rsp_table_full = full_ff;
   assign rsp_bound_mac  = bound_ff;

endmodule

// ----- hw/rtl/arp_binding_conflict_detector.sv -----
// channel  dir  ports                          tdata (low bit up)
// req      in   req_tvalid/tready/tdata[95:0]  frame_type, src_ip, src_mac
// rsp      out  rsp_tvalid/tready/tdata[55:0]  is_arp, conflict, learned,
//                                              table_full, bound_mac, zero pad
//
// Non-ARP beat: result in the cycle after accept. ARP beat: the scan reads the n
// stored bindings (n up to TABLE_ENTRIES), one table read per cycle through the
// single compare unit; a hit at entry k ends the scan early.
// Reset empties the table at once (fill count); no clearing pass.
// req_tready is low from accept until the result beat is taken.
module arp_binding_conflict_detector
   import abcd_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // frame_type, src_ip, src_mac
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // is_arp, conflict, learned, table_full,
                                             // bound_mac, pad
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [IP_W-1:0]  rd_ip, wr_ip;
   logic [MAC_W-1:0] rd_mac, wr_mac;
   logic             is_arp, conflict, learned, table_full;
   logic [MAC_W-1:0] bound_mac;

   abcd_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_frame_type (req_tdata[FRAME_TYPE_W-1:0]),
      .req_ip         (req_tdata[FRAME_TYPE_W +: IP_W]),
      .req_mac        (req_tdata[FRAME_TYPE_W+IP_W +: MAC_W]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_is_arp     (is_arp),
      .rsp_conflict   (conflict),
      .rsp_learned    (learned),
      .rsp_table_full (table_full),
      .rsp_bound_mac  (bound_mac),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_ip          (rd_ip),
      .rd_mac         (rd_mac),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_ip          (wr_ip),
      .wr_mac         (wr_mac)
   );

   abcd_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_ip   (rd_ip),
      .rd_mac  (rd_mac),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_ip   (wr_ip),
      .wr_mac  (wr_mac)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, bound_mac, table_full, learned, conflict, is_arp};

endmodule
